>>> hdl/cers_pkg.sv
// ----------------------------------------------------------------------------
// Column edge row scan: shared types and constants
// Register indexes, field widths, the tracker entry layout and the result
// record that travels from the update stage to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cers_pkg;

   // Field widths
   localparam int PIXEL_W     = 8;
   localparam int COLUMN_W    = 10;
   localparam int EDGE_ROW_W  = 11;
   localparam int FRAME_W_W   = 11;
   localparam int FRAME_H_W   = 12;
   localparam int THRESHOLD_W = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

   localparam logic [FRAME_W_W-1:0]   FRAME_WIDTH_RESET    = 11'd700;
   localparam logic [FRAME_H_W-1:0]   FRAME_HEIGHT_RESET   = 12'd480;
   localparam logic [THRESHOLD_W-1:0] EDGE_THRESHOLD_RESET = 8'd130;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int COUNT_W    = PTR_W + 1;

   // Tracker for one half of one column.
   typedef struct packed {
      logic                   seen;
      logic                   found;
      logic [EDGE_ROW_W-1:0]  row;
      logic [PIXEL_W-1:0]     max;
   } half_type;

   // One memory word holds both halves of a column.
   typedef struct packed {
      half_type upper;
      half_type lower;
   } entry_type;

   typedef struct packed {
      logic [COLUMN_W-1:0]   column;
      logic [EDGE_ROW_W-1:0] upper_edge_row;
      logic                  upper_by_threshold;
      logic [EDGE_ROW_W-1:0] lower_edge_row;
      logic                  lower_by_threshold;
      logic                  frame_done;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/cers_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Column edge row scan: result queue
// Small register queue that holds column results until the consumer takes
// them, so that the update stage never has to wait.
// ----------------------------------------------------------------------------
`default_nettype none

module cers_rsp_fifo
   import cers_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire result_type         push_data,
   input  wire logic               pop,
   output      logic               head_valid,
   output      result_type         head_data,
   output      logic [COUNT_W-1:0] count
);

   result_type         q_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = COUNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = COUNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = q_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

>>> hdl/column_edge_row_scan.sv
// ----------------------------------------------------------------------------
// Column edge row scan
// Finds an upper and a lower edge row for every column of an edge-magnitude
// frame delivered in raster order.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless stalled. Each pixel reads its
// column's tracker word from a single MAX_COLS-deep memory at the transfer
// edge, updates it in the following cycle and writes it back. A result is
// therefore pushed into the result queue from the update stage of the
// last-row pixel of its column and offered once the queue holds it. In a
// one-column frame a column is touched on consecutive pixels, and that case is
// served by forwarding the word just written. Results wait in a four-entry
// queue, and the input is stalled only while that queue together with the
// pixel in flight would overflow. Tracker words are cleared when a column's
// first-row pixel arrives, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module column_edge_row_scan
   import cers_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 2048
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // pixel input
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [PIXEL_W-1:0]     req_pixel,
   // column results
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [COLUMN_W-1:0]    rsp_column,
   output      logic [EDGE_ROW_W-1:0]  rsp_upper_edge_row,
   output      logic                   rsp_upper_by_threshold,
   output      logic [EDGE_ROW_W-1:0]  rsp_lower_edge_row,
   output      logic                   rsp_lower_by_threshold,
   output      logic                   rsp_frame_done
);

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int WCNT_W = $clog2(MAX_COLS + 1);
   localparam int HCNT_W = $clog2(MAX_ROWS + 1);

   // Configuration registers
   logic [FRAME_W_W-1:0]   frame_width_ff;
   logic [FRAME_H_W-1:0]   frame_height_ff;
   logic [THRESHOLD_W-1:0] edge_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RESET;
         frame_height_ff   <= FRAME_HEIGHT_RESET;
         edge_threshold_ff <= EDGE_THRESHOLD_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:    frame_width_ff    <= FRAME_W_W'(csr_wdata);
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            REG_EDGE_THRESHOLD: edge_threshold_ff <= THRESHOLD_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Frame size clamped to what the counters and the memory support.
   logic [WCNT_W-1:0] width_eff;
   logic [HCNT_W-1:0] height_eff;
   logic [HCNT_W-1:0] mid_row;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WCNT_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_COLS)) begin
         width_eff = WCNT_W'(MAX_COLS);
      end else begin
         width_eff = WCNT_W'(frame_width_ff);
      end
      if (32'(frame_height_ff) < 32'd2) begin
         height_eff = HCNT_W'(2);
      end else if (32'(frame_height_ff) > 32'(MAX_ROWS)) begin
         height_eff = HCNT_W'(MAX_ROWS);
      end else begin
         height_eff = HCNT_W'(frame_height_ff);
      end
      mid_row = height_eff >> 1;
   end

   // Raster position
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;
   logic             req_accept;
   logic             last_col;
   logic             last_row;
   logic             in_upper;

   assign req_accept = req_valid && !req_stall;
   assign last_col   = (WCNT_W'(WCNT_W'(col_ff) + 1'b1) >= width_eff);
   assign last_row   = (HCNT_W'(HCNT_W'(row_ff) + 1'b1) >= height_eff);
   assign in_upper   = (HCNT_W'(row_ff) < mid_row);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Update stage
   logic                  s1_valid_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [EDGE_ROW_W-1:0] s1_row_ff;
   logic [PIXEL_W-1:0]    s1_pixel_ff;
   logic                  s1_first_ff;
   logic                  s1_upper_ff;
   logic                  s1_over_ff;
   logic                  s1_last_row_ff;
   logic                  s1_last_col_ff;
   logic                  s1_fwd_ff;
   logic                  s1_fwd_in;

   // A transfer to the column being written back this cycle would read the
   // stale word, so it takes the written word instead.
   assign s1_fwd_in = s1_valid_ff && req_accept && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff      <= col_ff;
         s1_row_ff      <= EDGE_ROW_W'(row_ff);
         s1_pixel_ff    <= req_pixel;
         s1_first_ff    <= (row_ff == '0);
         s1_upper_ff    <= in_upper;
         s1_over_ff     <= (req_pixel > edge_threshold_ff);
         s1_last_row_ff <= last_row;
         s1_last_col_ff <= last_col;
         s1_fwd_ff      <= s1_fwd_in;
      end
   end

   // Tracker memory
   entry_type tracker_mem [MAX_COLS];
   entry_type rd_data_ff;
   entry_type fwd_data_ff;
   entry_type base_entry;
   entry_type new_entry;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         tracker_mem[s1_col_ff] <= new_entry;
      end
      if (req_accept) begin
         rd_data_ff <= tracker_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         fwd_data_ff <= new_entry;
      end
   end

   always_comb begin
      priority if (s1_first_ff) begin
         base_entry = '0;
      end else if (s1_fwd_ff) begin
         base_entry = fwd_data_ff;
      end else begin
         base_entry = rd_data_ff;
      end

      new_entry = base_entry;
      if (s1_upper_ff) begin
         // Upper half: the latest crossing wins, ties on the maximum go to
         // the later row.
         if (s1_over_ff) begin
            new_entry.upper.found = 1'b1;
            new_entry.upper.row   = s1_row_ff;
         end else if (!base_entry.upper.found &&
                      (!base_entry.upper.seen ||
                       s1_pixel_ff >= base_entry.upper.max)) begin
            new_entry.upper.max = s1_pixel_ff;
            new_entry.upper.row = s1_row_ff;
         end
         new_entry.upper.seen = 1'b1;
      end else if (!base_entry.lower.found) begin
         // Lower half: the first crossing is kept for good.
         if (s1_over_ff) begin
            new_entry.lower.found = 1'b1;
            new_entry.lower.row   = s1_row_ff;
         end else if (!base_entry.lower.seen ||
                      s1_pixel_ff > base_entry.lower.max) begin
            new_entry.lower.max = s1_pixel_ff;
            new_entry.lower.row = s1_row_ff;
         end
         new_entry.lower.seen = 1'b1;
      end
   end

   // Result queue
   result_type         result;
   result_type         head;
   logic               rsp_pop;
   logic [COUNT_W-1:0] fifo_count;

   always_comb begin
      result.column             = COLUMN_W'(s1_col_ff);
      result.upper_edge_row     = new_entry.upper.row;
      result.upper_by_threshold = new_entry.upper.found;
      result.lower_edge_row     = new_entry.lower.row;
      result.lower_by_threshold = new_entry.lower.found;
      result.frame_done         = s1_last_col_ff;
   end

   assign rsp_pop = rsp_valid && !rsp_stall;

   cers_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff && s1_last_row_ff),
      .push_data  (result),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head_data  (head),
      .count      (fifo_count)
   );

   // Room must remain for the pixel in flight and the one being offered.
   assign req_stall = ((COUNT_W+1)'(fifo_count) + (COUNT_W+1)'(s1_valid_ff)) >
                      (COUNT_W+1)'(FIFO_DEPTH - 1);

   assign rsp_column             = head.column;
   assign rsp_upper_edge_row     = head.upper_edge_row;
   assign rsp_upper_by_threshold = head.upper_by_threshold;
   assign rsp_lower_edge_row     = head.lower_edge_row;
   assign rsp_lower_by_threshold = head.lower_by_threshold;
   assign rsp_frame_done         = head.frame_done;

endmodule

`default_nettype wire

>>> hdl/cers_checker.sv
// ----------------------------------------------------------------------------
// Column edge row scan: port checker
// Concurrent assertions on the top level's ports, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cers_checker
   import cers_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [COLUMN_W-1:0]    rsp_column,
   input wire logic [EDGE_ROW_W-1:0]  rsp_upper_edge_row,
   input wire logic                   rsp_upper_by_threshold,
   input wire logic [EDGE_ROW_W-1:0]  rsp_lower_edge_row,
   input wire logic                   rsp_lower_by_threshold,
   input wire logic                   rsp_frame_done
);

   // After reset the block is empty and ready for a transfer.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("block not empty and ready after reset");

   // The input is held off only while results are waiting to be taken.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // A result appears on an empty output only after a pixel transfer has passed the update stage.
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without a pixel transfer");

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_stall |=>
                    rsp_valid && $stable(rsp_column) && $stable(rsp_upper_edge_row) &&
                    $stable(rsp_upper_by_threshold) && $stable(rsp_lower_edge_row) &&
                    $stable(rsp_lower_by_threshold) && $stable(rsp_frame_done))
      else $error("stalled result changed or was withdrawn");

endmodule

bind column_edge_row_scan cers_checker u_cers_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_column             (rsp_column),
   .rsp_upper_edge_row     (rsp_upper_edge_row),
   .rsp_upper_by_threshold (rsp_upper_by_threshold),
   .rsp_lower_edge_row     (rsp_lower_edge_row),
   .rsp_lower_by_threshold (rsp_lower_by_threshold),
   .rsp_frame_done         (rsp_frame_done)
);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Column edge row scan testbench
// Streams pixel frames into the block under varied handshake pacing, predicts
// the upper and lower edge rows of every column and checks each result
// transfer field by field against that prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cers_pkg::*;

   localparam int COLS           = 1024;
   localparam int ROWS           = 2048;
   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_PIXELS  = 340;
   localparam int RANDOM_RESULTS = 30;

   // One column, two rows: an upper crossing then a lower fallback at the
   // threshold itself, followed by the opposite arrangement.
   localparam logic [PIXEL_W-1:0] TINY_FRAMES [4] = '{8'd131, 8'd130, 8'd0, 8'd255};
   // Three columns, five rows, threshold zero, in raster order. The first
   // column is all zero, so both halves fall back to the rows next to mid.
   localparam logic [PIXEL_W-1:0] RASTER_3X5 [15] = '{
      8'd0, 8'd1, 8'd5,
      8'd0, 8'd0, 8'd7,
      8'd0, 8'd0, 8'd0,
      8'd0, 8'd1, 8'd0,
      8'd0, 8'd1, 8'd9};
   localparam logic [PIXEL_W-1:0] OPEN_FRAME [4] = '{8'd200, 8'd50, 8'd90, 8'd120};

   typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RSP_STALLS, PACE_BOTH} pace_type;

   typedef struct {
      bit                  seen;
      bit                  found;
      bit [EDGE_ROW_W-1:0] row;
      bit [PIXEL_W-1:0]    peak;
   } half_track_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_wen   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COLUMN_W-1:0]    rsp_column;
   logic [EDGE_ROW_W-1:0]  rsp_upper_edge_row;
   logic                   rsp_upper_by_threshold;
   logic [EDGE_ROW_W-1:0]  rsp_lower_edge_row;
   logic                   rsp_lower_by_threshold;
   logic                   rsp_frame_done;

   logic [PIXEL_W-1:0] pixels_to_send[$];
   result_type         column_reports_due[$];

   half_track_type       upper_half [COLS];
   half_track_type       lower_half [COLS];
   bit [FRAME_W_W-1:0]   cfg_width     = FRAME_WIDTH_RESET;
   bit [FRAME_H_W-1:0]   cfg_height    = FRAME_HEIGHT_RESET;
   bit [THRESHOLD_W-1:0] cfg_threshold = EDGE_THRESHOLD_RESET;
   int unsigned          row_pos       = 0;
   int unsigned          col_pos       = 0;

   int unsigned send_gap_pct = 0;
   int unsigned rsp_hold_pct = 0;
   int unsigned pixels_seen  = 0;
   int unsigned results_seen = 0;
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;

   column_edge_row_scan u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_pixel(input logic [PIXEL_W-1:0] pix);
      pixels_to_send = {pixels_to_send, pix};
   endfunction

   function automatic int unsigned active_width();
      if (cfg_width < 1) return 1;
      if (cfg_width > COLS) return COLS;
      return cfg_width;
   endfunction

   function automatic int unsigned active_height();
      if (cfg_height < 2) return 2;
      if (cfg_height > ROWS) return ROWS;
      return cfg_height;
   endfunction

   // Advances the frame position by one pixel and queues the column's
   // edge rows when the pixel belongs to the last row.
   function automatic void track_pixel(input logic [PIXEL_W-1:0] pix);
      int unsigned w, h, mid, r, c;
      bit          last_row, last_col;
      result_type  verdict;
      w        = active_width();
      h        = active_height();
      mid      = h / 2;
      r        = row_pos;
      c        = col_pos % COLS;
      last_row = (r + 1 >= h);
      last_col = (c + 1 >= w);
      if (r == 0) begin
         upper_half[c] = '{default: 0};
         lower_half[c] = '{default: 0};
      end
      if (r < mid) begin
         if (pix > cfg_threshold) begin
            upper_half[c].found = 1'b1;
            upper_half[c].row   = EDGE_ROW_W'(r);
         end else if (!upper_half[c].found &&
                      (!upper_half[c].seen || pix >= upper_half[c].peak)) begin
            upper_half[c].peak = pix;
            upper_half[c].row  = EDGE_ROW_W'(r);
         end
         upper_half[c].seen = 1'b1;
      end else if (!lower_half[c].found) begin
         if (pix > cfg_threshold) begin
            lower_half[c].found = 1'b1;
            lower_half[c].row   = EDGE_ROW_W'(r);
         end else if (!lower_half[c].seen || pix > lower_half[c].peak) begin
            lower_half[c].peak = pix;
            lower_half[c].row  = EDGE_ROW_W'(r);
         end
         lower_half[c].seen = 1'b1;
      end
      if (last_row) begin
         verdict.column             = COLUMN_W'(c);
         verdict.upper_edge_row     = upper_half[c].row;
         verdict.upper_by_threshold = upper_half[c].found;
         verdict.lower_edge_row     = lower_half[c].row;
         verdict.lower_by_threshold = lower_half[c].found;
         verdict.frame_done         = last_col;
         column_reports_due = {column_reports_due, verdict};
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic int unsigned pixels_to_frame_end();
      int unsigned w, h, row_left;
      w        = active_width();
      h        = active_height();
      row_left = (col_pos < w) ? w - col_pos : 1;
      if (row_pos + 1 >= h) return row_left;
      return (h - 1 - row_pos) * w + row_left;
   endfunction

   // hot_pct is the share of pixels above the threshold; the rest sit at or
   // below it, with repeated values so that ties for the maximum are common.
   function automatic logic [PIXEL_W-1:0] pick_pixel(input int unsigned hot_pct);
      if (cfg_threshold != 8'd255 && $urandom_range(99) < hot_pct)
         return PIXEL_W'($urandom_range(255, cfg_threshold + 1));
      if ($urandom_range(1) == 1)
         return PIXEL_W'($urandom_range(cfg_threshold, 0));
      case ($urandom_range(2))
         0: return cfg_threshold;
         1: return '0;
         default: return cfg_threshold >> 1;
      endcase
   endfunction

   function automatic void queue_pixels(input int unsigned count, input int unsigned hot_pct);
      repeat (count) add_pixel(pick_pixel(hot_pct));
   endfunction

   function automatic int unsigned random_width();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom_range(20, 9);
         default: return $urandom_range(8, 1);
      endcase
   endfunction

   function automatic int unsigned random_height();
      case ($urandom_range(9))
         0: return $urandom_range(1, 0);
         1: return $urandom_range(20, 13);
         default: return $urandom_range(12, 2);
      endcase
   endfunction

   function automatic int unsigned random_threshold();
      case ($urandom_range(5))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= 50)
         $display("ERROR cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_FULL: begin
            send_gap_pct = 0;
            rsp_hold_pct = 0;
         end
         PACE_SEND_GAPS: begin
            send_gap_pct = 54;
            rsp_hold_pct = 0;
         end
         PACE_RSP_STALLS: begin
            send_gap_pct = 0;
            rsp_hold_pct = 54;
         end
         default: begin
            send_gap_pct = 9;
            rsp_hold_pct = 9;
         end
      endcase
   endtask

   // Waits until every pixel has gone in and every result has come out, then
   // gives the pipeline time to finish pixels that produce no result.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pixels_to_send.size() != 0 || req_valid || column_reports_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         REG_FRAME_WIDTH:    cfg_width     = FRAME_W_W'(value);
         REG_FRAME_HEIGHT:   cfg_height    = FRAME_H_W'(value);
         REG_EDGE_THRESHOLD: cfg_threshold = THRESHOLD_W'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame(input int unsigned width, input int unsigned height,
                            input int unsigned threshold);
      write_reg(REG_FRAME_WIDTH, width);
      write_reg(REG_FRAME_HEIGHT, height);
      write_reg(REG_EDGE_THRESHOLD, threshold);
   endtask

   // Pixel driver: the next pixel is offered once the current one has been
   // taken, or after a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_pixel <= pixels_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && $urandom_range(99) < rsp_hold_pct;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         track_pixel(req_pixel);
         pixels_seen++;
      end
   end

   always @(posedge clock) begin
      result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (column_reports_due.size() == 0) begin
            report_error($sformatf("result transfer for column %0d with none due",
                                   rsp_column));
         end else begin
            due = column_reports_due.pop_front();
            check_field("column", rsp_column, due.column);
            check_field("upper_edge_row", rsp_upper_edge_row, due.upper_edge_row);
            check_field("upper_by_threshold", rsp_upper_by_threshold,
                        due.upper_by_threshold);
            check_field("lower_edge_row", rsp_lower_edge_row, due.lower_edge_row);
            check_field("lower_by_threshold", rsp_lower_by_threshold,
                        due.lower_by_threshold);
            check_field("frame_done", rsp_frame_done, due.frame_done);
         end
      end
   end

   initial begin
      int unsigned phase, total, w, hot, pixels_start, results_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Width and height below their ranges; the threshold keeps its value
      // from reset.
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_FRAME_HEIGHT, 1);
      foreach (TINY_FRAMES[i]) add_pixel(TINY_FRAMES[i]);

      wait_quiet();
      set_pace(PACE_SEND_GAPS);
      set_frame(3, 5, 0);
      foreach (RASTER_3X5[i]) add_pixel(RASTER_3X5[i]);

      // Height lowered after two rows: the third row becomes the last one and
      // falls into the lower half.
      wait_quiet();
      set_pace(PACE_RSP_STALLS);
      set_frame(2, 4, 100);
      foreach (OPEN_FRAME[i]) add_pixel(OPEN_FRAME[i]);
      wait_quiet();
      write_reg(REG_FRAME_HEIGHT, 2);
      add_pixel(8'd30);
      add_pixel(8'd101);

      // Width and height above their ranges for part of the first row, then
      // a narrow frame takes over from a column beyond its width.
      wait_quiet();
      set_pace(PACE_BOTH);
      set_frame(2047, 4095, 0);
      queue_pixels(30, 10);
      wait_quiet();
      set_pace(PACE_FULL);
      set_frame(3, 2, 200);
      queue_pixels(pixels_to_frame_end(), 10);
      wait_quiet();

      pixels_start  = pixels_seen;
      results_start = results_seen;
      phase         = 0;
      while (pixels_seen - pixels_start < RANDOM_PIXELS ||
             results_seen - results_start < RANDOM_RESULTS) begin
         set_pace(pace_type'(phase % 4));
         hot = $urandom_range(3) * 25;
         set_frame(random_width(), random_height(), random_threshold());
         total = pixels_to_frame_end();
         if ($urandom_range(3) != 0) begin
            queue_pixels(total * $urandom_range(2, 1), hot);
         end else begin
            // Part of a frame, then new settings while the frame is open.
            queue_pixels($urandom_range(total, 1), hot);
            wait_quiet();
            w = random_width();
            // Widening after the first row would leave the new columns
            // without a first-row transfer, so the width may not grow.
            if (row_pos != 0 && w > active_width())
               w = $urandom_range(active_width(), 0);
            set_frame(w, random_height(), random_threshold());
            queue_pixels(pixels_to_frame_end(), hot);
         end
         wait_quiet();
         phase++;
      end

      if (column_reports_due.size() != 0)
         report_error($sformatf("%0d results never arrived", column_reports_due.size()));
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
